// ----- sv/ckks_pkg.sv -----
// shared types, constants and helper functions for the canonical k-mer key splitter
// no dependencies; imported by ckks_keys, canonical_kmer_key_split and tb
package ckks_pkg;

    localparam int MAX_KMER_LEN = 31;
    localparam int KMER_W       = 2 * MAX_KMER_LEN;
    localparam int KEY_W        = KMER_W - 2;
    localparam int COUNT_W      = 32;
    localparam int LEN_W        = 5;
    localparam int BITS_W       = LEN_W + 1;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    typedef logic [KMER_W-1:0]     kmer_t;
    typedef logic [KEY_W-1:0]      key_t;
    typedef logic [1:0]            base_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [LEN_W-1:0]      len_t;
    typedef logic [BITS_W-1:0]     bits_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // configuration register indexes
    localparam cfg_idx_t REG_LOW_COVERAGE  = 2'd0;
    localparam cfg_idx_t REG_HIGH_COVERAGE = 2'd1;
    localparam cfg_idx_t REG_KMER_LEN      = 2'd2;

    localparam count_t LOW_COVERAGE_RST  = '0;
    localparam count_t HIGH_COVERAGE_RST = '1;
    localparam len_t   KMER_LEN_RST      = len_t'(21);
    localparam len_t   MIN_KMER_LEN      = len_t'(3);

    // complement of a base is its code xor this
    localparam base_t COMP_MASK = 2'b10;

    // live configuration seen by the pipeline
    typedef struct packed {
        count_t low_coverage;
        count_t high_coverage;
        len_t   kmer_len;
    } cfg_t;

    // effective k-mer length, short values raised to the minimum
    function automatic len_t eff_len(input len_t len);
        eff_len = (len < MIN_KMER_LEN) ? MIN_KMER_LEN : len;
    endfunction

    // mask of the low n bits of a k-mer word, n up to the full width
    function automatic kmer_t low_mask(input bits_t n);
        low_mask = ~({KMER_W{1'b1}} << n);
    endfunction

    // reverse complement over all base slots of the word
    function automatic kmer_t rev_comp_full(input kmer_t v);
        kmer_t r;
        r = '0;
        for (int i = 0; i < MAX_KMER_LEN; i++) begin
            r[2*(MAX_KMER_LEN-1-i) +: 2] = v[2*i +: 2] ^ COMP_MASK;
        end
        rev_comp_full = r;
    endfunction

endpackage

// ----- sv/ckks_keys.sv -----
// output stage: splits the canonical k-mer into middle, prefix and suffix keys
// depends on ckks_pkg; holds the result register toward the output channel
module ckks_keys (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            in_hit,
    input  ckks_pkg::kmer_t in_canon,
    input  ckks_pkg::len_t  len,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            in_range,
    output ckks_pkg::kmer_t canonical,
    output ckks_pkg::key_t  middle_key,
    output ckks_pkg::base_t middle_base,
    output ckks_pkg::key_t  prefix_key,
    output ckks_pkg::base_t last_base,
    output ckks_pkg::key_t  suffix_key,
    output ckks_pkg::base_t first_base
);
    import ckks_pkg::*;

    logic  valid_reg;
    logic  hit_reg;
    kmer_t canon_reg;
    key_t  mid_key_reg, pre_key_reg, suf_key_reg;
    base_t mid_base_reg, last_base_reg, first_base_reg;

    len_t  mid;
    bits_t first_pos;
    kmer_t mid_below, mid_above;
    kmer_t mid_shift, first_shift;
    key_t  mid_key_next, suf_key_next;

    // split positions from the effective length
    assign mid       = eff_len(len) - len_t'(1);
    assign first_pos = {eff_len(len), 1'b0} - bits_t'(2);

    // middle base removal: keep bits below, close up bits above
    assign mid_below    = in_canon & low_mask(bits_t'(mid));
    assign mid_above    = (in_canon >> (bits_t'(mid) + bits_t'(2))) << mid;
    assign mid_key_next = key_t'(mid_below | mid_above);
    assign mid_shift    = in_canon >> mid;

    // first base removal: the word has nothing above the first base
    assign suf_key_next = key_t'(in_canon & low_mask(first_pos));
    assign first_shift  = in_canon >> first_pos;

    assign in_ready = !valid_reg || out_ready;

    // output register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_ready) begin
            hit_reg        <= in_hit;
            canon_reg      <= in_canon;
            mid_key_reg    <= mid_key_next;
            mid_base_reg   <= mid_shift[1:0];
            pre_key_reg    <= in_canon[KMER_W-1:2];
            last_base_reg  <= in_canon[1:0];
            suf_key_reg    <= suf_key_next;
            first_base_reg <= first_shift[1:0];
        end
    end

    assign out_valid   = valid_reg;
    assign in_range    = hit_reg;
    assign canonical   = canon_reg;
    assign middle_key  = mid_key_reg;
    assign middle_base = mid_base_reg;
    assign prefix_key  = pre_key_reg;
    assign last_base   = last_base_reg;
    assign suffix_key  = suf_key_reg;
    assign first_base  = first_base_reg;

    // a rejected item leaves every field clear
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !hit_reg |->
            canon_reg == '0 && mid_key_reg == '0 && suf_key_reg == '0 &&
            mid_base_reg == '0 && first_base_reg == '0)
        else $error("rejected item carries nonzero fields");

    // prefix key and last base rebuild the canonical word
    a_prefix_split: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> {pre_key_reg, last_base_reg} == canon_reg)
        else $error("prefix split does not match canonical");

    // canonical value has no bits above the k-mer
    a_canon_width: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (canon_reg & ~low_mask({eff_len(len), 1'b0})) == '0)
        else $error("canonical has bits above the k-mer length");

endmodule

// ----- sv/canonical_kmer_key_split.sv -----
// top level of the canonical k-mer key splitter: config registers and pipeline
// depends on ckks_pkg and ckks_keys
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, kmer_value, count      | in
//  output  | out_valid, out_ready, in_range, keys/bases | out
//  config  | cfg_write, cfg_index, cfg_data             | in
//
// four register stages: range check and full reverse, length alignment,
// canonical compare, key split into the output register
// one transaction per cycle sustained while out_ready stays high
// each stage refills as soon as the stage ahead moves, so a bubble closes up
// an output stall holds the output register; in_ready drops once all four stages are full
// reset clears valid bits and loads the default configuration
module canonical_kmer_key_split (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  ckks_pkg::cfg_idx_t  cfg_index,
    input  ckks_pkg::cfg_data_t cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  ckks_pkg::kmer_t     kmer_value,
    input  ckks_pkg::count_t    count,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                in_range,
    output ckks_pkg::kmer_t     canonical,
    output ckks_pkg::key_t      middle_key,
    output ckks_pkg::base_t     middle_base,
    output ckks_pkg::key_t      prefix_key,
    output ckks_pkg::base_t     last_base,
    output ckks_pkg::key_t      suffix_key,
    output ckks_pkg::base_t     first_base
);
    import ckks_pkg::*;

    cfg_t  cfg_reg;
    bits_t kbits;

    logic  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic  s1_hit_reg, s2_hit_reg, s3_hit_reg;
    kmer_t s1_value_reg, s1_rc_reg;
    kmer_t s2_value_reg, s2_rc_reg;
    kmer_t s3_canon_reg;
    logic  s1_ready, s2_ready, s3_ready, keys_ready;
    logic  hit_next;
    kmer_t value_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.low_coverage  <= LOW_COVERAGE_RST;
            cfg_reg.high_coverage <= HIGH_COVERAGE_RST;
            cfg_reg.kmer_len      <= KMER_LEN_RST;
        end
        else if (cfg_write) begin
            unique case (cfg_index)
                REG_LOW_COVERAGE:  cfg_reg.low_coverage  <= cfg_data;
                REG_HIGH_COVERAGE: cfg_reg.high_coverage <= cfg_data;
                REG_KMER_LEN:      cfg_reg.kmer_len      <= cfg_data[LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    assign kbits = {eff_len(cfg_reg.kmer_len), 1'b0};

    // per-stage flow control
    assign s3_ready = !s3_valid_reg || keys_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // stage 1: coverage check, trim stray bits, reverse complement all slots
    assign hit_next   = (count >= cfg_reg.low_coverage) && (count <= cfg_reg.high_coverage);
    assign value_next = kmer_value & low_mask(kbits);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (s1_ready) begin
            s1_hit_reg   <= hit_next;
            s1_value_reg <= value_next;
            s1_rc_reg    <= rev_comp_full(value_next);
        end
        // stage 2: align reverse complement to the k-mer length
        if (s2_ready) begin
            s2_hit_reg   <= s1_hit_reg;
            s2_value_reg <= s1_value_reg;
            s2_rc_reg    <= s1_rc_reg >> (bits_t'(KMER_W) - kbits);
        end
        // stage 3: keep the smaller strand, clear rejected items
        if (s3_ready) begin
            s3_hit_reg <= s2_hit_reg;
            if (!s2_hit_reg) begin
                s3_canon_reg <= '0;
            end
            else if (s2_value_reg < s2_rc_reg) begin
                s3_canon_reg <= s2_value_reg;
            end
            else begin
                s3_canon_reg <= s2_rc_reg;
            end
        end
    end

    // stage 4: key split and output register
    ckks_keys u_keys (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s3_valid_reg),
        .in_ready    (keys_ready),
        .in_hit      (s3_hit_reg),
        .in_canon    (s3_canon_reg),
        .len         (cfg_reg.kmer_len),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .in_range    (in_range),
        .canonical   (canonical),
        .middle_key  (middle_key),
        .middle_base (middle_base),
        .prefix_key  (prefix_key),
        .last_base   (last_base),
        .suffix_key  (suffix_key),
        .first_base  (first_base)
    );

    // an accepted transaction occupies stage 1 next cycle
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted transaction missing from stage 1");

    // a blocked stage 1 holds its contents
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(s1_value_reg) &&
            $stable(s1_hit_reg))
        else $error("stage 1 changed while stalled");

    // a blocked stage 3 holds its contents
    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !keys_ready |=> s3_valid_reg && $stable(s3_canon_reg))
        else $error("stage 3 changed while stalled");

endmodule

// ----- test/tb.sv -----
// self-checking testbench for canonical_kmer_key_split
// depends on ckks_pkg; drives random valid/ready traffic and checks each result
// against a built-in canonical k-mer and key split predictor
module tb;
    import ckks_pkg::*;

    localparam int          DRAIN_CYCLES = 8;
    localparam int          LONG_STALL   = 60;
    localparam int          NUM_PHASES   = 9;
    localparam int          PHASE_ITEMS  = 128;
    localparam int          NUM_DIR      = 24;
    localparam int          MAX_REPORTS  = 100;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam cfg_idx_t    REG_SPARE    = 2'd3;
    localparam count_t      CNT_MAX      = '1;

    // one result transaction, fields in port order
    typedef struct packed {
        logic  in_range;
        kmer_t canonical;
        key_t  middle_key;
        base_t middle_base;
        key_t  prefix_key;
        base_t last_base;
        key_t  suffix_key;
        base_t first_base;
    } key_split_t;

    // one row of the directed stimulus, with its register settings
    typedef struct {
        count_t     lo;
        count_t     hi;
        cfg_data_t  len_word;
        kmer_t      kmer;
        count_t     cnt;
        bit         typed;
        key_split_t want;
    } dir_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_write = 1'b0;
    cfg_idx_t  cfg_index = '0;
    cfg_data_t cfg_data = '0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    kmer_t     kmer_value = '0;
    count_t    count = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    logic      in_range;
    kmer_t     canonical;
    key_t      middle_key;
    base_t     middle_base;
    key_t      prefix_key;
    base_t     last_base;
    key_t      suffix_key;
    base_t     first_base;

    // predictor copy of the configuration registers
    count_t cov_lo = '0;
    count_t cov_hi = '1;
    len_t   len_reg = len_t'(21);

    key_split_t  expected_splits [$];
    dir_row_t    dir_table [NUM_DIR];
    int          errors = 0;
    int unsigned cycle_count = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    bit          stall_req = 1'b0;

    canonical_kmer_key_split DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kmer_value  (kmer_value),
        .count       (count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .in_range    (in_range),
        .canonical   (canonical),
        .middle_key  (middle_key),
        .middle_base (middle_base),
        .prefix_key  (prefix_key),
        .last_base   (last_base),
        .suffix_key  (suffix_key),
        .first_base  (first_base)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_error(string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("error at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_error($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // remove the two bits at pos and pos+1, close up the rest
    function automatic key_t close_gap(logic [63:0] v, int unsigned pos);
        logic [63:0] below;
        logic [63:0] above;
        logic [63:0] joined;
        below  = v & ((64'd1 << pos) - 64'd1);
        above  = v >> (pos + 2);
        joined = below | (above << pos);
        return joined[KEY_W-1:0];
    endfunction

    // canonical form and the three split keys for one k-mer record
    function automatic key_split_t split_kmer(kmer_t kmer, count_t cnt);
        key_split_t  r;
        int unsigned len;
        int unsigned nbits;
        int unsigned i;
        logic [63:0] fwd;
        logic [63:0] rc;
        logic [63:0] canon;
        base_t       comp;
        r = '0;
        if (cnt < cov_lo || cnt > cov_hi)
            return r;
        // short lengths count as the minimum
        len = (len_reg < 3) ? 3 : len_reg;
        if (len > MAX_KMER_LEN)
            len = MAX_KMER_LEN;
        nbits = 2 * len;
        // bits above the k-mer are dropped
        fwd = {2'b00, kmer} & ((64'd1 << nbits) - 64'd1);
        rc  = '0;
        for (i = 0; i < len; i++)
        begin
            comp = fwd[2*i +: 2] ^ COMP_MASK;
            rc   = rc | (64'(comp) << (2 * (len - 1 - i)));
        end
        canon = (fwd < rc) ? fwd : rc;
        r.in_range    = 1'b1;
        r.canonical   = canon[KMER_W-1:0];
        r.middle_key  = close_gap(canon, len - 1);
        r.middle_base = canon[len-1 +: 2];
        r.prefix_key  = close_gap(canon, 0);
        r.last_base   = canon[1:0];
        r.suffix_key  = close_gap(canon, nbits - 2);
        r.first_base  = canon[nbits-2 +: 2];
        return r;
    endfunction

    // counts bunched around both edges of the coverage window, or fully random
    function automatic count_t pick_count();
        case ($urandom_range(0, 3))
            0: return cov_lo + count_t'($urandom_range(0, 4)) - count_t'(2);
            1: return cov_hi + count_t'($urandom_range(0, 4)) - count_t'(2);
            default: return count_t'($urandom);
        endcase
    endfunction

    // offer one input transaction, record its expectation when accepted
    task automatic offer(kmer_t kmer, count_t cnt, key_split_t want);
        int gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kmer_value <= kmer;
        count      <= cnt;
        do @(posedge clk); while (in_ready !== 1'b1);
        expected_splits.insert(expected_splits.size(), want);
    endtask

    // stop sending and let the pipeline empty
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_splits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register writes, only with the pipeline empty
    task automatic set_config(count_t lo, count_t hi, cfg_data_t len_word, bit poke_spare);
        cfg_idx_t  idx [4];
        cfg_data_t val [4];
        int        nw;
        int        i;
        wait_for_results();
        idx = '{REG_LOW_COVERAGE, REG_HIGH_COVERAGE, REG_KMER_LEN, REG_SPARE};
        val = '{lo, hi, len_word, cfg_data_t'($urandom)};
        nw  = poke_spare ? 4 : 3;
        for (i = 0; i < nw; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        cov_lo  = lo;
        cov_hi  = hi;
        len_reg = len_word[LEN_W-1:0];
    endtask

    // result side: random or long hold-off, then check each transaction
    initial
    begin : result_sink
        int         hold;
        key_split_t got;
        key_split_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            if (stall_req)
            begin
                hold      = LONG_STALL;
                stall_req = 1'b0;
            end
            else
                hold = rx_idle ? $urandom_range(0, 5) : 0;
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            got = {in_range, canonical, middle_key, middle_base,
                   prefix_key, last_base, suffix_key, first_base};
            if (expected_splits.size() == 0)
                report_error("result transaction with nothing expected");
            else
            begin
                want = expected_splits.pop_front();
                compare_field("in_range", 64'(got.in_range), 64'(want.in_range));
                compare_field("canonical", 64'(got.canonical), 64'(want.canonical));
                compare_field("middle_key", 64'(got.middle_key), 64'(want.middle_key));
                compare_field("middle_base", 64'(got.middle_base), 64'(want.middle_base));
                compare_field("prefix_key", 64'(got.prefix_key), 64'(want.prefix_key));
                compare_field("last_base", 64'(got.last_base), 64'(want.last_base));
                compare_field("suffix_key", 64'(got.suffix_key), 64'(want.suffix_key));
                compare_field("first_base", 64'(got.first_base), 64'(want.first_base));
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        key_split_t all_a;
        key_split_t miss;
        key_split_t want;
        dir_row_t   row;
        count_t     lo;
        count_t     hi;
        count_t     cnt;
        cfg_data_t  lw;
        kmer_t      kmer;
        bit         poke;
        int         len;
        int         ph;
        int         n;
        int         r;

        miss  = '0;
        all_a = '0;
        all_a.in_range = 1'b1;

        // directed rows: extremes, length limits, even length, window edges, empty and single-value windows
        dir_table = '{
            // reset settings; all-A k-mer is already canonical
            '{32'd0, CNT_MAX, 32'd21, 62'h0, 32'd0, 1'b1, all_a},
            '{32'd0, CNT_MAX, 32'd21, '1, CNT_MAX, 1'b0, miss},
            '{32'd0, CNT_MAX, 32'd21, 62'h2AAA_AAAA_AAAA_AAAA, 32'd1, 1'b0, miss},
            // everything above the k-mer set, below all zero
            '{32'd0, CNT_MAX, 32'd21, 62'h3FFF_FC00_0000_0000, 32'd5, 1'b1, all_a},
            '{32'd0, CNT_MAX, 32'd21, 62'h1234_5678_9ABC_DEF0, 32'd77, 1'b0, miss},
            // shortest and longest lengths
            '{32'd0, CNT_MAX, 32'd3, 62'h39, 32'd9, 1'b0, miss},
            '{32'd0, CNT_MAX, 32'd31, '1, 32'd9, 1'b0, miss},
            '{32'd0, CNT_MAX, 32'd31, 62'h0, 32'd9, 1'b1, all_a},
            '{32'd0, CNT_MAX, 32'd31, 62'h1555_5555_5555_5555, 32'd9, 1'b0, miss},
            // lengths below the minimum
            '{32'd0, CNT_MAX, 32'd0, 62'h1B, 32'd3, 1'b0, miss},
            '{32'd0, CNT_MAX, 32'd1, 62'h2D, 32'd3, 1'b0, miss},
            '{32'd0, CNT_MAX, 32'd2, 62'h3FFF_FFFF_FFFF_FFC6, 32'd3, 1'b0, miss},
            // even lengths, one a reverse-complement palindrome
            '{32'd0, CNT_MAX, 32'd4, 62'h22, 32'd3, 1'b0, miss},
            '{32'd0, CNT_MAX, 32'd30, 62'h0ABC_DEF0_1234_5678, 32'd3, 1'b0, miss},
            // window edges
            '{32'd100, 32'd200, 32'd21, 62'h0F0F_0F0F_0F0F, 32'd99, 1'b1, miss},
            '{32'd100, 32'd200, 32'd21, 62'h0F0F_0F0F_0F0F, 32'd100, 1'b0, miss},
            '{32'd100, 32'd200, 32'd21, 62'h3C3C_3C3C_3C3C, 32'd200, 1'b0, miss},
            '{32'd100, 32'd200, 32'd21, 62'h3C3C_3C3C_3C3C, 32'd201, 1'b1, miss},
            // empty window
            '{32'd200, 32'd100, 32'd21, 62'h1111_1111, 32'd150, 1'b1, miss},
            '{32'd200, 32'd100, 32'd21, 62'h1111_1111, 32'd100, 1'b1, miss},
            // single-value windows at both ends of the count range
            '{CNT_MAX, CNT_MAX, 32'd21, 62'h0246_8ACE, CNT_MAX, 1'b0, miss},
            '{CNT_MAX, CNT_MAX, 32'd21, 62'h0246_8ACE, CNT_MAX - 1, 1'b1, miss},
            '{32'd0, 32'd0, 32'd21, 62'h3_7777_7777, 32'd0, 1'b0, miss},
            '{32'd0, 32'd0, 32'd21, 62'h3_7777_7777, 32'd1, 1'b1, miss}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        for (r = 0; r < NUM_DIR; r++)
        begin
            row = dir_table[r];
            if (row.lo != cov_lo || row.hi != cov_hi || row.len_word[LEN_W-1:0] != len_reg)
                set_config(row.lo, row.hi, row.len_word, 1'b0);
            want = row.typed ? row.want : split_kmer(row.kmer, row.cnt);
            offer(row.kmer, row.cnt, want);
        end

        // random part, one register setting per phase
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            poke    = 1'b0;
            tx_idle = 1'b1;
            rx_idle = 1'b1;
            len     = 2 * $urandom_range(1, 15) + 1;
            lo      = count_t'($urandom);
            hi      = count_t'($urandom);
            case (ph)
                0:
                begin
                    lo      = '0;
                    hi      = '1;
                    len     = MAX_KMER_LEN;
                    tx_idle = 1'b0;
                    rx_idle = 1'b0;
                end
                1:
                begin
                    lo  = '0;
                    hi  = '1;
                    len = 3;
                end
                2:
                begin
                    if (lo > hi)
                        {lo, hi} = {hi, lo};
                    poke = 1'b1;
                end
                3:
                    hi = lo;
                4:
                begin
                    // empty window
                    hi = count_t'($urandom_range(0, 32'h7FFF_FFFF));
                    lo = hi + 1 + count_t'($urandom_range(0, 1000));
                end
                5:
                begin
                    lo = '1;
                    hi = '1;
                end
                6:
                begin
                    lo  = '0;
                    len = $urandom_range(0, 31);
                end
                7:
                begin
                    lo = '0;
                    hi = '1;
                end
                default:
                begin
                    if (lo > hi)
                        {lo, hi} = {hi, lo};
                    len = $urandom_range(0, 31);
                end
            endcase
            lw = cfg_data_t'($urandom);
            lw[LEN_W-1:0] = len_t'(len);
            set_config(lo, hi, lw, poke);

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // long output hold-off with back-to-back input to fill the pipeline
                if (ph == 7 && n == 20)
                begin
                    stall_req = 1'b1;
                    tx_idle   = 1'b0;
                end
                if (ph == 7 && n == 60)
                    tx_idle = 1'b1;
                kmer = kmer_t'({$urandom, $urandom});
                cnt  = pick_count();
                offer(kmer, cnt, split_kmer(kmer, cnt));
            end
        end

        wait_for_results();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
